[src/signed_int_to_decimal_ascii_assert.svh]
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii assertion macros
// Short forms for the concurrent checks that the top level uses.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Condition a implies condition c in the same cycle.
`define SIDA_ASSERT_SAME(name, clk, rst_n, a, c) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("sida assertion failed");

// Condition a implies condition c in the next cycle.
`define SIDA_ASSERT_NEXT(name, clk, rst_n, a, c) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("sida assertion failed");

`endif

[src/sida_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_pkg
// Types and constants shared by the integer to decimal text converter.
// ---------------------------------------------------------------------------
package sida_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 6;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned CountW    = 4;

  localparam logic [CharW-1:0] CharMinus = 6'd45;
  localparam logic [CharW-1:0] CharZero  = 6'd48;

  // floor(x / 10) == (x * RecipTen) >> RecipShift for every 32-bit x.
  localparam logic [ValueW-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned       RecipShift = 35;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSign,
    StEmit
  } sida_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic sign_sel;
    logic dec;
  } sida_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic idx_zero;
  } sida_status_t;

endpackage

[src/sida_dpath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_dpath
// Magnitude register, divide-by-ten step and digit store with read-out.
// ---------------------------------------------------------------------------
module sida_dpath
  import sida_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [ValueW-1:0] value_i,
  input  sida_cmd_t                cmd_i,
  output sida_status_t             status_o,
  output logic [CharW-1:0]         ascii_char_o,
  output logic                     last_char_o
);

  logic [ValueW-1:0]   mag_q, mag_d;
  logic                neg_q;
  logic [DigitW-1:0]   digits_q [NumDigits];
  logic [CountW-1:0]   nd_q;
  logic [CountW-1:0]   idx_q;

  logic [ValueW-1:0]   raw;
  logic [2*ValueW-1:0] prod;
  logic [ValueW-1:0]   quot;
  logic [ValueW-1:0]   quot_x10;
  logic [ValueW-1:0]   rem;

  assign raw      = value_i;
  assign prod     = (2*ValueW)'(mag_q) * (2*ValueW)'(RecipTen);
  assign quot     = ValueW'(prod[2*ValueW-1:RecipShift]);
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem      = mag_q - quot_x10;
  assign mag_d    = raw[ValueW-1] ? (ValueW'(0) - raw) : raw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= mag_d;
      neg_q <= raw[ValueW-1];
      nd_q  <= '0;
    end else if (cmd_i.step) begin
      digits_q[nd_q] <= rem[DigitW-1:0];
      mag_q          <= quot;
      nd_q           <= nd_q + CountW'(1);
      // Tracks the most significant digit written so far.
      idx_q          <= nd_q;
    end else if (cmd_i.dec) begin
      idx_q <= idx_q - CountW'(1);
    end
  end

  assign status_o.conv_done = (quot == '0) || (nd_q == CountW'(NumDigits - 1));
  assign status_o.neg       = neg_q;
  assign status_o.idx_zero  = (idx_q == '0);

  assign ascii_char_o = cmd_i.sign_sel ? CharMinus
                                       : CharZero + CharW'(digits_q[idx_q]);
  assign last_char_o  = !cmd_i.sign_sel && (idx_q == '0);

endmodule

[src/sida_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sida_ctrl
// Sequencer: accept, digit extraction, sign and digit output.
// ---------------------------------------------------------------------------
module sida_ctrl
  import sida_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  sida_status_t status_i,
  output sida_cmd_t    cmd_o
);

  sida_state_e state_q, state_d;
  logic        out_take;

  assign out_take = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StConv;
      end
      StConv: begin
        if (status_i.conv_done) state_d = status_i.neg ? StSign : StEmit;
      end
      StSign: begin
        if (!out_stall_i) state_d = StEmit;
      end
      StEmit: begin
        if (!out_stall_i && status_i.idx_zero) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      StConv: begin
        cmd_o.step = 1'b1;
      end
      StSign: begin
        out_valid_o    = 1'b1;
        cmd_o.sign_sel = 1'b1;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        cmd_o.dec   = out_take;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

[src/signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed 32-bit integer into its decimal ASCII text.
// ---------------------------------------------------------------------------
// One item is taken at a time. After acceptance the magnitude is divided by
// ten once per cycle through a 32x32 reciprocal multiply, one digit per
// cycle. The text then leaves one character per cycle while out_stall_i is
// low, minus sign first for negative values, most significant digit next,
// with last_char_o set on the final digit. The input is stalled for the
// whole conversion.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [CharW-1:0]         ascii_char_o,
  output logic                     last_char_o
);

  sida_cmd_t    cmd;
  sida_status_t status;

  sida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sida_dpath u_dpath (
    .clk_i        (clk_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o)
  );

`include "signed_int_to_decimal_ascii_assert.svh"

  // No new item is taken while text is still going out.
  `SIDA_ASSERT_SAME(a_no_accept_while_emit, clk_i, rst_ni, out_valid_o, in_stall_o)
  // At least one divide step follows every accepted item.
  `SIDA_ASSERT_NEXT(a_conv_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, !out_valid_o)
  // The final character is always a digit, never the sign.
  `SIDA_ASSERT_SAME(a_last_is_digit, clk_i, rst_ni, out_valid_o && last_char_o, ascii_char_o != CharMinus)
  // Once the final character is taken the block is ready again.
  `SIDA_ASSERT_NEXT(a_ready_after_last, clk_i, rst_ni, out_valid_o && !out_stall_i && last_char_o, !in_stall_o)

endmodule
